/* sv/set_assoc_writeback_cache_tags_macros.svh */
// assertion macros for the cache tag store checker
// expects signals named clock and reset in the scope of use
`ifndef SET_ASSOC_WRITEBACK_CACHE_TAGS_MACROS_SVH
`define SET_ASSOC_WRITEBACK_CACHE_TAGS_MACROS_SVH

// checked only outside reset
`define SAWCT_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// checked on every edge, reset included
`define SAWCT_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) \
      else $error(msg);

`endif

/* sv/sawct_pkg.sv */
// shared types and constants of the cache tag store
// no dependencies
`default_nettype none

package sawct_pkg;

   localparam int ADDR_BITS  = 32;
   localparam int TAG_W      = 29;
   localparam int SET_IDX_W  = 13;
   localparam int OFF_W      = 12;
   localparam int CFG_W      = 4;
   localparam int CSR_IDX_W  = 2;
   localparam int SIZE_W     = 2;
   localparam int REFS_W     = 2;
   localparam int TOTAL_W    = 32;
   localparam int WAYS_CNT_W = 5;
   localparam int BIT_SEL_W  = 4;

   localparam logic [CFG_W-1:0] OB_MIN     = 4'd3;
   localparam logic [CFG_W-1:0] OB_MAX     = 4'd12;
   localparam logic [CFG_W-1:0] IB_MAX     = 4'd13;
   localparam logic [CFG_W-1:0] OB_RESET   = 4'd3;
   localparam logic [CFG_W-1:0] IB_RESET   = 4'd0;
   localparam logic [CFG_W-1:0] WAYS_RESET = 4'd1;

   localparam logic [BIT_SEL_W-1:0] SET_MSB = 4'd12;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_OFFSET_BITS = 2'd0,
      CSR_INDEX_BITS  = 2'd1,
      CSR_WAYS_IN_USE = 2'd2
   } csr_idx_type;

   typedef enum logic [REFS_W-1:0] {
      REFS_NONE  = 2'd0,
      REFS_FILL  = 2'd1,
      REFS_EVICT = 2'd2
   } refs_type;

   typedef enum logic [5:0] {
      ST_CLEAR  = 6'b000001,
      ST_IDLE   = 6'b000010,
      ST_DECODE = 6'b000100,
      ST_MOD    = 6'b001000,
      ST_SCAN   = 6'b010000,
      ST_WRITE  = 6'b100000
   } state_type;

   // low address bits that must be zero for an aligned access
   function automatic logic [2:0] size_mask(input logic [SIZE_W-1:0] size_log2);
      logic [2:0] m;
      unique case (size_log2)
         2'd0:    m = 3'b000;
         2'd1:    m = 3'b001;
         2'd2:    m = 3'b011;
         default: m = 3'b111;
      endcase
      return m;
   endfunction

endpackage

`default_nettype wire

/* sv/sawct_ram.sv */
// generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module sawct_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                   clock,
   input  wire logic                                   wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                       wr_data,
   input  wire logic                                   rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

/* sv/set_assoc_writeback_cache_tags.sv */
// Tag store of a write-back, write-allocate set-associative data cache.
// Request channel (req_*): mode, byte address and log2 access size. A request
// is taken when req_valid is high and req_stall is low. Response channel
// (rsp_*): hit, memory references, tag, set, offset and running hit and miss
// totals, held stable while rsp_stall is high. The csr_* port writes the
// line size, set count and ways in use; write it only while idle.
// One transaction at a time: a shared tag/use-count compare unit walks the
// ways of the set, one ram read per cycle. A request passes decode, the
// way scan and the write step, where the response is registered, and the
// next request is taken only after that; when MAX_SETS is not a power of two
// the set index is first reduced by a 13-step remainder unit.
// A misaligned request is taken and dropped, and gives no response.
// A finished result waits in the output register; a stalled receiver holds
// the block in its write step, so new requests are taken once it drains.
// After reset all 2^(clog2(MAX_SETS)+clog2(MAX_WAYS)) tag ram lines
// (65536 by default) are cleared, one line per cycle, with req_stall
// high; csr writes are taken throughout.
// Depends on sawct_pkg and sawct_ram.
`default_nettype none

module set_assoc_writeback_cache_tags
   import sawct_pkg::*;
#(
   parameter int MAX_SETS        = 8192,
   parameter int MAX_WAYS        = 8,
   parameter int USE_COUNT_WIDTH = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic                  req_mode,
   input  wire logic [ADDR_BITS-1:0]  req_address,
   input  wire logic [SIZE_W-1:0]     req_size_log2,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic                       rsp_hit,
   output logic      [REFS_W-1:0]     rsp_mem_refs,
   output logic      [TAG_W-1:0]      rsp_tag,
   output logic      [SET_IDX_W-1:0]  rsp_set_index,
   output logic      [OFF_W-1:0]      rsp_offset,
   output logic      [TOTAL_W-1:0]    rsp_hit_total,
   output logic      [TOTAL_W-1:0]    rsp_miss_total,
   input  wire logic                  csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CFG_W-1:0]      csr_wr_data
);

   localparam int SET_W     = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
   localparam int WAY_W     = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   localparam int RAM_AW    = SET_W + WAY_W;
   localparam int RAM_DEPTH = 2 ** RAM_AW;
   localparam int CNT_W     = USE_COUNT_WIDTH;
   localparam int LINE_W    = CNT_W + TAG_W + 2;
   localparam int DIRTY_BIT = CNT_W;
   localparam int TAG_LSB   = CNT_W + 1;
   localparam int VALID_BIT = LINE_W - 1;
   localparam int MOD_W     = SET_W + 1;
   localparam bit SETS_POW2 = ((MAX_SETS & (MAX_SETS - 1)) == 0);
   localparam bit ONE_SET   = (MAX_SETS == 1);

   // configuration
   logic [CFG_W-1:0] offset_bits_ff, offset_bits_in;
   logic [CFG_W-1:0] index_bits_ff, index_bits_in;
   logic [CFG_W-1:0] ways_in_use_ff, ways_in_use_in;

   // control
   state_type         state_ff, state_in;
   logic [RAM_AW-1:0] clr_addr_ff, clr_addr_in;
   logic              issue_on_ff, issue_on_in;
   logic              cmp_vld_ff, cmp_vld_in;
   logic [TOTAL_W-1:0] hits_ff, hits_in;
   logic [TOTAL_W-1:0] misses_ff, misses_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // transaction payload
   logic                 mode_ff, mode_in;
   logic [ADDR_BITS-1:0] addr_ff, addr_in;
   logic [OFF_W-1:0]     off_ff, off_in;
   logic [SET_IDX_W-1:0] set_raw_ff, set_raw_in;
   logic [TAG_W-1:0]     tag_ff, tag_in;
   logic [SET_W-1:0]     set_ff, set_in;
   logic [MOD_W-1:0]     rem_ff, rem_in;
   logic [BIT_SEL_W-1:0] rbit_ff, rbit_in;
   logic [WAY_W-1:0]     issue_way_ff, issue_way_in;
   logic [WAY_W-1:0]     cmp_way_ff, cmp_way_in;

   // scan results
   logic             hit_found_ff, hit_found_in;
   logic [WAY_W-1:0] hit_way_ff, hit_way_in;
   logic [CNT_W-1:0] hit_cnt_ff, hit_cnt_in;
   logic             hit_dirty_ff, hit_dirty_in;
   logic             free_found_ff, free_found_in;
   logic [WAY_W-1:0] free_way_ff, free_way_in;
   logic [WAY_W-1:0] vic_way_ff, vic_way_in;
   logic [CNT_W-1:0] vic_cnt_ff, vic_cnt_in;
   logic             vic_dirty_ff, vic_dirty_in;

   // response register
   logic                 rsp_hit_ff, rsp_hit_in;
   refs_type             rsp_refs_ff, rsp_refs_in;
   logic [TAG_W-1:0]     rsp_tag_ff, rsp_tag_in;
   logic [SET_IDX_W-1:0] rsp_set_ff, rsp_set_in;
   logic [OFF_W-1:0]     rsp_off_ff, rsp_off_in;
   logic [TOTAL_W-1:0]   rsp_hits_ff, rsp_hits_in;
   logic [TOTAL_W-1:0]   rsp_misses_ff, rsp_misses_in;

   // ram
   logic              ram_wr_en;
   logic [RAM_AW-1:0] ram_wr_addr;
   logic [LINE_W-1:0] ram_wr_data;
   logic              ram_rd_en;
   logic [RAM_AW-1:0] ram_rd_addr;
   logic [LINE_W-1:0] ram_rd_data;

   // combinational helpers
   logic [CFG_W-1:0]      ob, ib;
   logic [WAYS_CNT_W-1:0] ways_eff;
   logic                  req_accept, misaligned, out_free;
   logic [4:0]            tag_shift;
   logic [ADDR_BITS-1:0]  off_mask, set_mask;
   logic [SET_IDX_W-1:0]  set_raw_dec;
   logic [MOD_W-1:0]      trial, trial_red;
   logic                  rd_valid, rd_dirty;
   logic [TAG_W-1:0]      rd_tag;
   logic [CNT_W-1:0]      rd_cnt;
   logic [WAY_W-1:0]      sel_way;
   logic [CNT_W-1:0]      new_cnt;
   logic                  new_dirty;
   refs_type              new_refs;
   logic [LINE_W-1:0]     new_line;

   function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] c);
      return (c == {CNT_W{1'b1}}) ? c : c + 1'b1;
   endfunction

   function automatic logic [TOTAL_W-1:0] sat_inc(input logic [TOTAL_W-1:0] v);
      return (v == {TOTAL_W{1'b1}}) ? v : v + 1'b1;
   endfunction

   function automatic logic is_last(input logic [WAY_W-1:0] w,
                                    input logic [WAYS_CNT_W-1:0] n);
      return (WAYS_CNT_W'(w) + 1'b1) == n;
   endfunction

   assign ob = (offset_bits_ff < OB_MIN) ? OB_MIN :
               ((offset_bits_ff > OB_MAX) ? OB_MAX : offset_bits_ff);
   assign ib = (index_bits_ff > IB_MAX) ? IB_MAX : index_bits_ff;
   assign ways_eff = (ways_in_use_ff == '0) ? WAYS_CNT_W'(1) :
                     ((WAYS_CNT_W'(ways_in_use_ff) > WAYS_CNT_W'(MAX_WAYS)) ?
                      WAYS_CNT_W'(MAX_WAYS) : WAYS_CNT_W'(ways_in_use_ff));

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign misaligned = |(req_address[2:0] & size_mask(req_size_log2));
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   // address split
   assign tag_shift   = 5'(ob) + 5'(ib);
   assign off_mask    = (ADDR_BITS'(1) << ob) - ADDR_BITS'(1);
   assign set_mask    = (ADDR_BITS'(1) << ib) - ADDR_BITS'(1);
   assign set_raw_dec = SET_IDX_W'((addr_ff >> ob) & set_mask);

   // one restoring step of the set remainder
   assign trial     = {rem_ff[SET_W-1:0], set_raw_ff[rbit_ff]};
   assign trial_red = (trial >= MOD_W'(MAX_SETS)) ? trial - MOD_W'(MAX_SETS) : trial;

   assign rd_valid = ram_rd_data[VALID_BIT];
   assign rd_tag   = ram_rd_data[TAG_LSB +: TAG_W];
   assign rd_dirty = ram_rd_data[DIRTY_BIT];
   assign rd_cnt   = ram_rd_data[CNT_W-1:0];

   // line update chosen by the scan
   always_comb begin
      if (hit_found_ff) begin
         sel_way   = hit_way_ff;
         new_cnt   = bump(hit_cnt_ff);
         new_dirty = hit_dirty_ff | mode_ff;
         new_refs  = REFS_NONE;
      end else if (free_found_ff) begin
         sel_way   = free_way_ff;
         new_cnt   = '0;
         new_dirty = mode_ff;
         new_refs  = REFS_FILL;
      end else begin
         sel_way   = vic_way_ff;
         new_cnt   = bump(vic_cnt_ff);
         new_dirty = mode_ff;
         new_refs  = vic_dirty_ff ? REFS_EVICT : REFS_FILL;
      end
      new_line = {1'b1, tag_ff, new_dirty, new_cnt};
   end

   assign ram_rd_en   = (state_ff == ST_SCAN) && issue_on_ff;
   assign ram_rd_addr = {set_ff, issue_way_ff};
   assign ram_wr_en   = (state_ff == ST_CLEAR) || ((state_ff == ST_WRITE) && out_free);
   assign ram_wr_addr = (state_ff == ST_CLEAR) ? clr_addr_ff : {set_ff, sel_way};
   assign ram_wr_data = (state_ff == ST_CLEAR) ? '0 : new_line;

   always_comb begin
      offset_bits_in = offset_bits_ff;
      index_bits_in  = index_bits_ff;
      ways_in_use_in = ways_in_use_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_OFFSET_BITS: offset_bits_in = csr_wr_data;
            CSR_INDEX_BITS:  index_bits_in  = csr_wr_data;
            CSR_WAYS_IN_USE: ways_in_use_in = csr_wr_data;
            default:         ;
         endcase
      end
   end

   always_comb begin
      state_in      = state_ff;
      clr_addr_in   = clr_addr_ff;
      issue_on_in   = issue_on_ff;
      cmp_vld_in    = cmp_vld_ff;
      hits_in       = hits_ff;
      misses_in     = misses_ff;
      rsp_valid_in  = rsp_valid_ff;
      mode_in       = mode_ff;
      addr_in       = addr_ff;
      off_in        = off_ff;
      set_raw_in    = set_raw_ff;
      tag_in        = tag_ff;
      set_in        = set_ff;
      rem_in        = rem_ff;
      rbit_in       = rbit_ff;
      issue_way_in  = issue_way_ff;
      cmp_way_in    = cmp_way_ff;
      hit_found_in  = hit_found_ff;
      hit_way_in    = hit_way_ff;
      hit_cnt_in    = hit_cnt_ff;
      hit_dirty_in  = hit_dirty_ff;
      free_found_in = free_found_ff;
      free_way_in   = free_way_ff;
      vic_way_in    = vic_way_ff;
      vic_cnt_in    = vic_cnt_ff;
      vic_dirty_in  = vic_dirty_ff;
      rsp_hit_in    = rsp_hit_ff;
      rsp_refs_in   = rsp_refs_ff;
      rsp_tag_in    = rsp_tag_ff;
      rsp_set_in    = rsp_set_ff;
      rsp_off_in    = rsp_off_ff;
      rsp_hits_in   = rsp_hits_ff;
      rsp_misses_in = rsp_misses_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_CLEAR: begin
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == {RAM_AW{1'b1}}) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            // misaligned transactions are taken and dropped here
            if (req_accept && !misaligned) begin
               mode_in  = req_mode;
               addr_in  = req_address;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            off_in     = OFF_W'(addr_ff & off_mask);
            set_raw_in = set_raw_dec;
            tag_in     = TAG_W'(addr_ff >> tag_shift);
            rem_in     = '0;
            rbit_in    = SET_MSB;
            if (SETS_POW2) begin
               set_in   = ONE_SET ? '0 : SET_W'(set_raw_dec);
               state_in = ST_SCAN;
            end else begin
               state_in = ST_MOD;
            end
            issue_way_in  = '0;
            issue_on_in   = 1'b1;
            cmp_vld_in    = 1'b0;
            hit_found_in  = 1'b0;
            free_found_in = 1'b0;
         end
         ST_MOD: begin
            rem_in  = trial_red;
            rbit_in = rbit_ff - 1'b1;
            if (rbit_ff == '0) begin
               set_in   = SET_W'(trial_red);
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // read of one way overlaps the compare of the previous one
            cmp_vld_in = issue_on_ff;
            cmp_way_in = issue_way_ff;
            if (issue_on_ff) begin
               if (is_last(issue_way_ff, ways_eff)) begin
                  issue_on_in = 1'b0;
               end else begin
                  issue_way_in = issue_way_ff + 1'b1;
               end
            end
            if (cmp_vld_ff) begin
               if (rd_valid && (rd_tag == tag_ff) && !hit_found_ff) begin
                  hit_found_in = 1'b1;
                  hit_way_in   = cmp_way_ff;
                  hit_cnt_in   = rd_cnt;
                  hit_dirty_in = rd_dirty;
               end
               if (!rd_valid && !free_found_ff) begin
                  free_found_in = 1'b1;
                  free_way_in   = cmp_way_ff;
               end
               // strict less-than keeps the lowest way on ties
               if ((cmp_way_ff == '0) || (rd_cnt < vic_cnt_ff)) begin
                  vic_way_in   = cmp_way_ff;
                  vic_cnt_in   = rd_cnt;
                  vic_dirty_in = rd_dirty;
               end
               if (is_last(cmp_way_ff, ways_eff)) begin
                  state_in = ST_WRITE;
               end
            end
         end
         ST_WRITE: begin
            if (out_free) begin
               if (hit_found_ff) begin
                  hits_in     = sat_inc(hits_ff);
                  rsp_hits_in = sat_inc(hits_ff);
                  rsp_misses_in = misses_ff;
               end else begin
                  misses_in     = sat_inc(misses_ff);
                  rsp_misses_in = sat_inc(misses_ff);
                  rsp_hits_in   = hits_ff;
               end
               rsp_hit_in   = hit_found_ff;
               rsp_refs_in  = new_refs;
               rsp_tag_in   = tag_ff;
               rsp_set_in   = set_raw_ff;
               rsp_off_in   = off_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_bits_ff <= OB_RESET;
         index_bits_ff  <= IB_RESET;
         ways_in_use_ff <= WAYS_RESET;
         state_ff       <= ST_CLEAR;
         clr_addr_ff    <= '0;
         issue_on_ff    <= 1'b0;
         cmp_vld_ff     <= 1'b0;
         hits_ff        <= '0;
         misses_ff      <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         offset_bits_ff <= offset_bits_in;
         index_bits_ff  <= index_bits_in;
         ways_in_use_ff <= ways_in_use_in;
         state_ff       <= state_in;
         clr_addr_ff    <= clr_addr_in;
         issue_on_ff    <= issue_on_in;
         cmp_vld_ff     <= cmp_vld_in;
         hits_ff        <= hits_in;
         misses_ff      <= misses_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      addr_ff       <= addr_in;
      off_ff        <= off_in;
      set_raw_ff    <= set_raw_in;
      tag_ff        <= tag_in;
      set_ff        <= set_in;
      rem_ff        <= rem_in;
      rbit_ff       <= rbit_in;
      issue_way_ff  <= issue_way_in;
      cmp_way_ff    <= cmp_way_in;
      hit_found_ff  <= hit_found_in;
      hit_way_ff    <= hit_way_in;
      hit_cnt_ff    <= hit_cnt_in;
      hit_dirty_ff  <= hit_dirty_in;
      free_found_ff <= free_found_in;
      free_way_ff   <= free_way_in;
      vic_way_ff    <= vic_way_in;
      vic_cnt_ff    <= vic_cnt_in;
      vic_dirty_ff  <= vic_dirty_in;
      rsp_hit_ff    <= rsp_hit_in;
      rsp_refs_ff   <= rsp_refs_in;
      rsp_tag_ff    <= rsp_tag_in;
      rsp_set_ff    <= rsp_set_in;
      rsp_off_ff    <= rsp_off_in;
      rsp_hits_ff   <= rsp_hits_in;
      rsp_misses_ff <= rsp_misses_in;
   end

   sawct_ram #(
      .WIDTH (LINE_W),
      .DEPTH (RAM_DEPTH)
   ) u_tag_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hit        = rsp_hit_ff;
   assign rsp_mem_refs   = rsp_refs_ff;
   assign rsp_tag        = rsp_tag_ff;
   assign rsp_set_index  = rsp_set_ff;
   assign rsp_offset     = rsp_off_ff;
   assign rsp_hit_total  = rsp_hits_ff;
   assign rsp_miss_total = rsp_misses_ff;

endmodule

`default_nettype wire

/* sv/sawct_checker.sv */
// port-level checks for the cache tag store, bound to the top level
// depends on sawct_pkg and set_assoc_writeback_cache_tags_macros.svh
`default_nettype none
`include "set_assoc_writeback_cache_tags_macros.svh"

module sawct_checker
   import sawct_pkg::*;
(
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 req_stall,
   input wire logic                 rsp_valid,
   input wire logic                 rsp_stall,
   input wire logic                 rsp_hit,
   input wire logic [REFS_W-1:0]    rsp_mem_refs,
   input wire logic [TAG_W-1:0]     rsp_tag,
   input wire logic [SET_IDX_W-1:0] rsp_set_index,
   input wire logic [TOTAL_W-1:0]   rsp_hit_total,
   input wire logic [TOTAL_W-1:0]   rsp_miss_total
);

   // stalled response stays put
   `SAWCT_ASSERT(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_tag) && $stable(rsp_set_index) && $stable(rsp_hit_total) && $stable(rsp_miss_total), "stalled response changed")

   // memory traffic agrees with the hit flag
   `SAWCT_ASSERT(a_refs_hit, rsp_valid && rsp_hit |-> rsp_mem_refs == REFS_NONE, "hit with memory traffic")
   `SAWCT_ASSERT(a_refs_miss, rsp_valid && !rsp_hit |-> rsp_mem_refs == REFS_FILL || rsp_mem_refs == REFS_EVICT, "miss without a fill")

   // the tag ram clear blocks requests and no response follows reset
   `SAWCT_ASSERT_ALWAYS(a_reset_clear, reset |=> req_stall && !rsp_valid, "block open right after reset")

endmodule

bind set_assoc_writeback_cache_tags sawct_checker u_sawct_checker (.*);

`default_nettype wire

/* dv/tag_store_checker.sv */
// checker for the cache tag store: watches the request, response and csr ports,
// predicts each lookup result and compares it field by field
// depends on sawct_pkg
module tag_store_checker
   import sawct_pkg::*;
#(
   parameter int MAX_SETS        = 8192,
   parameter int MAX_WAYS        = 8,
   parameter int USE_COUNT_WIDTH = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_stall,
   input  logic                 req_mode,
   input  logic [ADDR_BITS-1:0] req_address,
   input  logic [SIZE_W-1:0]    req_size_log2,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  logic                 rsp_hit,
   input  logic [REFS_W-1:0]    rsp_mem_refs,
   input  logic [TAG_W-1:0]     rsp_tag,
   input  logic [SET_IDX_W-1:0] rsp_set_index,
   input  logic [OFF_W-1:0]     rsp_offset,
   input  logic [TOTAL_W-1:0]   rsp_hit_total,
   input  logic [TOTAL_W-1:0]   rsp_miss_total,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wr_data,
   output int                   fail_count,
   output int                   waiting,
   output int                   n_hits,
   output int                   n_fills,
   output int                   n_dirty_evictions,
   output int                   n_dropped
);

   localparam int LINES = MAX_SETS * MAX_WAYS;
   localparam longint unsigned USE_MAX = (64'd1 << USE_COUNT_WIDTH) - 64'd1;

   typedef struct packed {
      logic                 hit;
      refs_type             mem_refs;
      logic [TAG_W-1:0]     tag;
      logic [SET_IDX_W-1:0] set_index;
      logic [OFF_W-1:0]     offset;
      logic [TOTAL_W-1:0]   hit_total;
      logic [TOTAL_W-1:0]   miss_total;
   } lookup_t;

   bit               line_valid [LINES];
   bit [TAG_W-1:0]   line_tag   [LINES];
   bit               line_dirty [LINES];
   int unsigned      line_use   [LINES];
   logic [TOTAL_W-1:0] hits_seen, misses_seen;
   logic [CFG_W-1:0] cfg_offset_bits, cfg_index_bits, cfg_ways;

   lookup_t expected_lookups[$];
   int      mismatch_count;

   assign fail_count = mismatch_count + waiting;

   function automatic int unsigned bump_use(input int unsigned c);
      return (c >= USE_MAX) ? int'(USE_MAX) : c + 1;
   endfunction

   // returns 0 for a misaligned access, which gives no response
   function automatic bit predict_lookup(input logic write_access,
                                         input logic [ADDR_BITS-1:0] addr,
                                         input logic [SIZE_W-1:0] size_log2,
                                         output lookup_t outcome);
      int unsigned ob, ib, ways, set_sel, base, victim;
      logic [TAG_W-1:0] tag;
      int found_way, free_way;
      outcome = '0;
      ob = (cfg_offset_bits < OB_MIN) ? OB_MIN :
           (cfg_offset_bits > OB_MAX) ? OB_MAX : cfg_offset_bits;
      ib = (cfg_index_bits > IB_MAX) ? IB_MAX : cfg_index_bits;
      ways = (cfg_ways == 0) ? 1 : cfg_ways;
      if (ways > MAX_WAYS) ways = MAX_WAYS;
      if ((addr & ((32'd1 << size_log2) - 32'd1)) != 32'd0) return 1'b0;

      set_sel = (addr >> ob) & ((32'd1 << ib) - 32'd1);
      tag = addr >> (ob + ib);
      base = (set_sel % MAX_SETS) * MAX_WAYS;

      // lowest matching way wins when a tag sits in more than one way
      found_way = -1;
      for (int w = 0; w < ways && found_way < 0; w++)
         if (line_valid[base + w] && line_tag[base + w] == tag) found_way = w;

      if (found_way >= 0) begin
         if (hits_seen != '1) hits_seen++;
         line_use[base + found_way] = bump_use(line_use[base + found_way]);
         if (write_access) line_dirty[base + found_way] = 1'b1;
         outcome.hit = 1'b1;
         outcome.mem_refs = REFS_NONE;
      end else begin
         if (misses_seen != '1) misses_seen++;
         free_way = -1;
         for (int w = 0; w < ways && free_way < 0; w++)
            if (!line_valid[base + w]) free_way = w;
         if (free_way >= 0) begin
            line_valid[base + free_way] = 1'b1;
            line_tag[base + free_way]   = tag;
            line_dirty[base + free_way] = write_access;
            line_use[base + free_way]   = 0;
            outcome.mem_refs = REFS_FILL;
         end else begin
            victim = 0;
            for (int w = 1; w < ways; w++)
               if (line_use[base + w] < line_use[base + victim]) victim = w;
            outcome.mem_refs = line_dirty[base + victim] ? REFS_EVICT : REFS_FILL;
            line_tag[base + victim]   = tag;
            line_dirty[base + victim] = write_access;
            line_use[base + victim]   = bump_use(line_use[base + victim]);
         end
      end
      outcome.tag        = tag;
      outcome.set_index  = set_sel;
      outcome.offset     = addr & ((32'd1 << ob) - 32'd1);
      outcome.hit_total  = hits_seen;
      outcome.miss_total = misses_seen;
      return 1'b1;
   endfunction

   task automatic flag_mismatch(input string what, input logic [31:0] exp_val,
                                input logic [31:0] act_val);
      if (mismatch_count < 10)
         $display("mismatch on %s: expected 0x%0h, got 0x%0h", what, exp_val, act_val);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      lookup_t oldest, predicted;
      if (reset) begin
         for (int i = 0; i < LINES; i++) begin
            line_valid[i] = 1'b0;
            line_tag[i]   = '0;
            line_dirty[i] = 1'b0;
            line_use[i]   = 0;
         end
         hits_seen = '0;
         misses_seen = '0;
         cfg_offset_bits = OB_RESET;
         cfg_index_bits  = IB_RESET;
         cfg_ways        = WAYS_RESET;
         expected_lookups.delete();
         waiting = 0;
         mismatch_count = 0;
         n_hits = 0;
         n_fills = 0;
         n_dirty_evictions = 0;
         n_dropped = 0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_OFFSET_BITS: cfg_offset_bits = csr_wr_data;
               CSR_INDEX_BITS:  cfg_index_bits  = csr_wr_data;
               CSR_WAYS_IN_USE: cfg_ways        = csr_wr_data;
               default: ;
            endcase
         end

         // a response always belongs to an earlier request
         if (rsp_valid && !rsp_stall) begin
            if (expected_lookups.size() == 0) begin
               flag_mismatch("unexpected response, tag", '0, rsp_tag);
            end else begin
               oldest = expected_lookups.pop_front();
               waiting--;
               if (rsp_hit !== oldest.hit) flag_mismatch("hit", oldest.hit, rsp_hit);
               if (rsp_mem_refs !== oldest.mem_refs)
                  flag_mismatch("mem_refs", oldest.mem_refs, rsp_mem_refs);
               if (rsp_tag !== oldest.tag) flag_mismatch("tag", oldest.tag, rsp_tag);
               if (rsp_set_index !== oldest.set_index)
                  flag_mismatch("set_index", oldest.set_index, rsp_set_index);
               if (rsp_offset !== oldest.offset)
                  flag_mismatch("offset", oldest.offset, rsp_offset);
               if (rsp_hit_total !== oldest.hit_total)
                  flag_mismatch("hit_total", oldest.hit_total, rsp_hit_total);
               if (rsp_miss_total !== oldest.miss_total)
                  flag_mismatch("miss_total", oldest.miss_total, rsp_miss_total);
            end
         end

         if (req_valid && !req_stall) begin
            if (predict_lookup(req_mode, req_address, req_size_log2, predicted)) begin
               expected_lookups.push_back(predicted);
               waiting++;
               if (predicted.hit) n_hits++;
               else if (predicted.mem_refs == REFS_EVICT) n_dirty_evictions++;
               else n_fills++;
            end else begin
               n_dropped++;
            end
         end
      end
   end

endmodule

/* dv/tb_top.sv */
// top of the cache tag store testbench: clock, reset, csr setup and access stimulus
// with random idling on both channels; checking lives in tag_store_checker
// depends on sawct_pkg, set_assoc_writeback_cache_tags and tag_store_checker
module tb_top;
   import sawct_pkg::*;

   localparam int SETS  = 8192;
   localparam int WAYS  = 8;
   localparam int USE_W = 16;

   localparam int IDLE_PCT        = 38;
   localparam int SETTLE_CYCLES   = 24;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int WATCHDOG_LIMIT  = 262144;
   localparam int SAT_HITS        = 65540;

   localparam logic ACC_READ  = 1'b0;
   localparam logic ACC_WRITE = 1'b1;
   // index with no register behind it, writes must be ignored
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   logic                 clock, reset;
   logic                 req_valid, req_stall, req_mode;
   logic [ADDR_BITS-1:0] req_address;
   logic [SIZE_W-1:0]    req_size_log2;
   logic                 rsp_valid, rsp_stall, rsp_hit;
   logic [REFS_W-1:0]    rsp_mem_refs;
   logic [TAG_W-1:0]     rsp_tag;
   logic [SET_IDX_W-1:0] rsp_set_index;
   logic [OFF_W-1:0]     rsp_offset;
   logic [TOTAL_W-1:0]   rsp_hit_total, rsp_miss_total;
   logic                 csr_wr_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CFG_W-1:0]     csr_wr_data;

   int fail_count, waiting, n_hits, n_fills, n_dirty_evictions, n_dropped;
   int unsigned geo_ob, geo_ib, geo_ways;
   int n_settings;
   bit quiet;
   bit hold_off_request;
   int idle_cycles;

   set_assoc_writeback_cache_tags #(
      .MAX_SETS(SETS), .MAX_WAYS(WAYS), .USE_COUNT_WIDTH(USE_W)
   ) u_dut (.*);

   tag_store_checker #(
      .MAX_SETS(SETS), .MAX_WAYS(WAYS), .USE_COUNT_WIDTH(USE_W)
   ) u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // receiver side: random stalls, quiet stretches and one long hold-off
   initial begin
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end else begin
            rsp_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
         end
      end
   end

   // ends the run when nothing moves for too long (covers the clearing pass)
   initial begin
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
         else idle_cycles++;
      end
      $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("** set_assoc_writeback_cache_tags: FAILED **");
      $finish;
   end

   function automatic logic [ADDR_BITS-1:0] make_addr(input logic [31:0] tag,
                                                      input logic [31:0] set_sel,
                                                      input logic [31:0] off);
      return (tag << (geo_ob + geo_ib)) | (set_sel << geo_ob) | off;
   endfunction

   task automatic send_access(input logic mode, input logic [ADDR_BITS-1:0] addr,
                              input logic [SIZE_W-1:0] size_log2);
      if (!quiet) begin
         while ($urandom_range(99) < IDLE_PCT) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid     <= 1'b1;
      req_mode      <= mode;
      req_address   <= addr;
      req_size_log2 <= size_log2;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // registers change only once every response is back and the block has settled
   task automatic set_geometry(input logic [CFG_W-1:0] ob, input logic [CFG_W-1:0] ib,
                               input logic [CFG_W-1:0] ways);
      req_valid <= 1'b0;
      @(posedge clock);
      wait (waiting == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= CSR_OFFSET_BITS;
      csr_wr_data <= ob;
      @(posedge clock);
      csr_index   <= CSR_INDEX_BITS;
      csr_wr_data <= ib;
      @(posedge clock);
      csr_index   <= CSR_WAYS_IN_USE;
      csr_wr_data <= ways;
      @(posedge clock);
      csr_index   <= CSR_SPARE;
      csr_wr_data <= $urandom;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      geo_ob   = (ob < OB_MIN) ? OB_MIN : (ob > OB_MAX) ? OB_MAX : ob;
      geo_ib   = (ib > IB_MAX) ? IB_MAX : ib;
      geo_ways = (ways == 0) ? 1 : (ways > WAYS) ? WAYS : ways;
      n_settings++;
   endtask

   // mostly accesses to a few hot sets with a tag pool a bit larger than the
   // associativity, so hits, fills and evictions all show up; the rest is noise
   task automatic run_mix(input int n_items, input bit with_hold);
      logic [31:0] tag_pool [10];
      logic [31:0] hot_set [3];
      logic [31:0] tag_mask, set_mask, off_mask;
      logic [ADDR_BITS-1:0] addr;
      logic [SIZE_W-1:0] sz;
      int pool_n, r;
      tag_mask = 32'hFFFF_FFFF >> (geo_ob + geo_ib);
      set_mask = (32'd1 << geo_ib) - 32'd1;
      off_mask = (32'd1 << geo_ob) - 32'd1;
      pool_n = geo_ways + 2;
      for (int i = 0; i < pool_n; i++)
         tag_pool[i] = (i % 3 == 2) ? ($urandom & tag_mask) : i;
      hot_set[0] = 0;
      hot_set[1] = set_mask;
      hot_set[2] = $urandom & set_mask;
      for (int k = 0; k < n_items; k++) begin
         if (with_hold && k == n_items / 3) hold_off_request = 1'b1;
         r  = $urandom_range(99);
         sz = $urandom_range(3);
         if (r < 8) begin
            addr = $urandom;
         end else begin
            addr = make_addr(tag_pool[$urandom_range(pool_n - 1)],
                             hot_set[$urandom_range(2)],
                             $urandom & off_mask & ~((32'd1 << sz) - 32'd1));
            if (r < 13 && sz != 0) addr[0] = 1'b1;
         end
         send_access($urandom_range(1) ? ACC_WRITE : ACC_READ, addr, sz);
      end
   endtask

   initial begin
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_mode      <= ACC_READ;
      req_address   <= '0;
      req_size_log2 <= '0;
      csr_wr_en     <= 1'b0;
      csr_index     <= CSR_OFFSET_BITS;
      csr_wr_data   <= '0;
      quiet = 1'b0;
      hold_off_request = 1'b0;
      n_settings = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // single set, two ways: fills, hits, clean and dirty evictions, ties
      set_geometry(4'd3, 4'd0, 4'd2);
      send_access(ACC_READ, 32'h0000_0000, 2'd3);
      send_access(ACC_WRITE, 32'h0000_0008, 2'd3);
      send_access(ACC_READ, 32'h0000_0000, 2'd2);
      send_access(ACC_WRITE, 32'h0000_0004, 2'd2);
      send_access(ACC_READ, 32'h0000_0010, 2'd1);
      send_access(ACC_WRITE, 32'h0000_0018, 2'd0);
      send_access(ACC_READ, 32'h0000_0020, 2'd3);
      send_access(ACC_READ, 32'h0000_0028, 2'd3);
      send_access(ACC_READ, 32'h0000_0030, 2'd3);
      // misaligned, dropped without a response
      send_access(ACC_READ, 32'h0000_0001, 2'd1);
      send_access(ACC_WRITE, 32'h0000_0002, 2'd2);
      send_access(ACC_READ, 32'h0000_0004, 2'd3);
      send_access(ACC_WRITE, 32'hFFFF_FFFF, 2'd3);
      // top of the address space
      send_access(ACC_WRITE, 32'hFFFF_FFFF, 2'd0);
      send_access(ACC_READ, 32'hFFFF_FFF8, 2'd3);
      send_access(ACC_READ, 32'hFFFF_FFFE, 2'd1);

      // same tag in two ways after the way count shrinks and grows again
      set_geometry(4'd12, 4'd13, 4'd2);
      send_access(ACC_READ, make_addr(5, 8191, 0), 2'd0);
      send_access(ACC_WRITE, make_addr(6, 8191, 0), 2'd0);
      set_geometry(4'd12, 4'd13, 4'd1);
      send_access(ACC_READ, make_addr(6, 8191, 0), 2'd0);
      set_geometry(4'd12, 4'd13, 4'd2);
      send_access(ACC_READ, make_addr(6, 8191, 0), 2'd0);
      send_access(ACC_READ, make_addr(5, 8191, 0), 2'd0);

      // drive one line's use count into saturation, then force a victim choice
      set_geometry(4'd3, 4'd1, 4'd2);
      send_access(ACC_READ, make_addr(32'h0ABC_DEF, 1, 0), 2'd3);
      send_access(ACC_WRITE, make_addr(32'h0ABC_DF0, 1, 0), 2'd3);
      quiet = 1'b1;
      for (int i = 0; i < SAT_HITS; i++)
         send_access(ACC_READ, make_addr(32'h0ABC_DEF, 1, 0), 2'd3);
      for (int i = 0; i < 10; i++)
         send_access(ACC_READ, make_addr(32'h0ABC_DF0, 1, 0), 2'd3);
      send_access(ACC_READ, make_addr(32'h0ABC_DF1, 1, 0), 2'd3);
      send_access(ACC_READ, make_addr(32'h0ABC_DF2, 1, 0), 2'd3);
      quiet = 1'b0;

      set_geometry(4'd3, 4'd0, 4'd1);
      run_mix(170, 1'b0);
      set_geometry(4'd12, 4'd13, 4'd8);
      run_mix(170, 1'b1);
      set_geometry(4'd3, 4'd13, 4'd8);
      run_mix(170, 1'b0);
      set_geometry(4'd12, 4'd0, 4'd1);
      run_mix(170, 1'b0);
      set_geometry(4'd5, 4'd4, 4'd4);
      run_mix(170, 1'b0);
      set_geometry(4'd8, 4'd2, 4'd2);
      run_mix(170, 1'b0);
      // out-of-range register values are clamped by the block
      set_geometry(4'd0, 4'd15, 4'd0);
      run_mix(170, 1'b0);
      set_geometry(4'd15, 4'd14, 4'd15);
      run_mix(170, 1'b0);
      set_geometry(4'd4, 4'd1, 4'd9);
      run_mix(170, 1'b0);
      set_geometry($urandom_range(3, 12), $urandom_range(0, 13), $urandom_range(1, 8));
      run_mix(170, 1'b0);

      req_valid <= 1'b0;
      @(posedge clock);
      wait (waiting == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("covered %0d lookups: %0d hits, %0d clean fills, %0d dirty evictions; %0d dropped",
               n_hits + n_fills + n_dirty_evictions, n_hits, n_fills, n_dirty_evictions,
               n_dropped);
      $display("across %0d register settings, a use-count saturation burst and a %0d-cycle hold-off",
               n_settings, HOLD_OFF_CYCLES);
      if (fail_count == 0) begin
         $display("** set_assoc_writeback_cache_tags: PASSED **");
      end else begin
         $display("%0d failures", fail_count);
         $display("** set_assoc_writeback_cache_tags: FAILED **");
      end
      $finish;
   end

endmodule
